// ===== src/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SHF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define SHF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/shf_pkg.sv =====
// Package of the scanline hachure fill: sizes, codes, edge entry type, helpers.
`default_nettype none
package shf_pkg;

  localparam int MAX_EDGES   = 32;
  localparam int MAX_RESULTS = 16;
  localparam int EDGE_AW     = $clog2(MAX_EDGES);
  localparam int ECW         = $clog2(MAX_EDGES + 1);
  localparam int DIVW        = 41;
  localparam int DCW         = $clog2(DIVW + 1);

  localparam logic signed [23:0] Y_MAX   = 24'sh7FFFFF;
  localparam logic [23:0]        GAP_MIN = 24'd26;

  // Input operation codes
  localparam logic FN_VERTEX  = 1'b0;
  localparam logic FN_ADVANCE = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_HACHURE_GAP  = 2'd0;
  localparam logic [1:0] CFG_STROKE_WIDTH = 2'd1;

  typedef enum logic [1:0] {
    PH_PENDING = 2'd0,
    PH_ACTIVE  = 2'd1,
    PH_RETIRED = 2'd2
  } phase_t;

  typedef struct packed {
    phase_t             phase;
    logic signed [23:0] low_y;
    logic signed [23:0] high_y;
    logic signed [47:0] cur_x;
    logic signed [47:0] inv_slope;
  } edge_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DIV, S_EWRITE, S_CLOSE, S_MIN_RD, S_MIN_CHK, S_PH_RD, S_PH_CHK,
    S_DECIDE, S_SORT_RD, S_SORT_CHK, S_SORT_END, S_EMPTY, S_GAP, S_UPD_RD,
    S_UPD_CHK, S_UPD_MUL, S_FINISH
  } state_t;

  typedef struct packed {
    logic                   start;
    logic signed [DIVW-1:0] num;
    logic signed [24:0]     den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [47:0] quot;
  } div_rsp_t;

  // Q32.16 to integer, half away from zero, saturated to 16 bits
  function automatic logic signed [15:0] round_q16(input logic signed [47:0] x);
    logic signed [48:0] xe;
    logic [48:0]        mag;
    logic [32:0]        r;
    xe  = {x[47], x};
    mag = x[47] ? 49'(-xe) : 49'(xe);
    r   = 33'((mag + 49'h8000) >> 16);
    if (!x[47]) begin
      round_q16 = (r > 33'd32767) ? 16'sh7FFF : 16'(r);
    end else begin
      round_q16 = (r > 33'd32768) ? 16'sh8000 : 16'(-r);
    end
  endfunction

endpackage
`default_nettype wire

// ===== src/shf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module shf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/shf_div.sv =====
// Restoring divider for edge inverse slopes, one quotient bit per cycle.
`default_nettype none
module shf_div (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire shf_pkg::div_req_t req,
  output shf_pkg::div_rsp_t      rsp
);

  localparam int W = shf_pkg::DIVW;

  logic               busy;
  logic [shf_pkg::DCW-1:0] cnt;
  logic [24:0]        rem;
  logic [W-1:0]       q;
  logic [24:0]        dmag;
  logic               neg;
  logic               done;
  logic [25:0]        rem_sh;
  logic               qbit;
  logic signed [47:0] qext;

  // Trial subtract of the shifted remainder
  always_comb begin
    rem_sh = {rem, q[W-1]};
    qbit   = (rem_sh >= {1'b0, dmag});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= shf_pkg::DCW'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == shf_pkg::DCW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: magnitudes in, signed quotient truncated toward zero out
  always_ff @(posedge clk) begin
    if (req.start) begin
      q    <= req.num[W-1] ? W'(-req.num) : W'(req.num);
      dmag <= req.den[24] ? 25'(-req.den) : 25'(req.den);
      neg  <= req.num[W-1] ^ req.den[24];
      rem  <= '0;
    end else if (busy) begin
      rem <= qbit ? 25'(rem_sh - {1'b0, dmag}) : rem_sh[24:0];
      q   <= {q[W-2:0], qbit};
    end
  end

  assign qext     = 48'($signed({1'b0, q}));
  assign rsp.done = done;
  assign rsp.quot = neg ? -qext : qext;

endmodule
`default_nettype wire

// ===== src/shf_xstep.sv =====
// Edge x advance: x + floor(gap * slope / 256), saturated to 48 bits.
`default_nettype none
module shf_xstep (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [23:0]        gap,
  input  wire logic signed [47:0] slope,
  input  wire logic signed [47:0] x,
  output logic                    done,
  output logic signed [47:0]      x_new
);

  logic [3:0]         stage;
  logic [23:0]        gap_r;
  logic signed [47:0] slope_r;
  logic signed [47:0] x_r;
  logic signed [24:0] mb;
  logic signed [49:0] prod;
  logic signed [49:0] plo;
  logic signed [49:0] phi;
  logic signed [64:0] p;
  logic signed [56:0] stp;
  logic signed [57:0] sum;

  // One 25x25 multiplier, low half of the slope first, then the high half
  always_comb begin
    mb   = stage[0] ? $signed({1'b0, slope_r[23:0]}) : $signed({slope_r[47], slope_r[47:24]});
    prod = $signed({1'b0, gap_r}) * mb;
    p    = ($signed(65'(phi)) <<< 24) + 65'(plo);
    sum  = 58'(x_r) + 58'(stp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
      done  <= 1'b0;
    end else begin
      stage <= {stage[2:0], start};
      done  <= stage[3];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      gap_r   <= gap;
      slope_r <= slope;
      x_r     <= x;
    end
    if (stage[0]) plo <= prod;
    if (stage[1]) phi <= prod;
    if (stage[2]) stp <= 57'(p >>> 8);
    if (stage[3]) begin
      if (sum > 58'sh7FFFFFFFFFFF) begin
        x_new <= 48'sh7FFFFFFFFFFF;
      end else if (sum < -58'sh800000000000) begin
        x_new <= 48'sh800000000000;
      end else begin
        x_new <= sum[47:0];
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/scanline_hachure_fill.sv =====
// Top level of the scanline hachure fill: sequencer around the edge memory.
//
// Vertices and advance steps arrive as items while busy is low; busy is high
// until an item's work is done, and a step's finish item appears on the outputs
// as busy falls. A vertex that adds an edge holds busy through the slope divider
// and then one memory write; other vertices leave busy low. An advance step runs
// a phase pass over the stored edges, two sort sweeps per span and an x update of
// the active edges, all paced by the one edge memory read port; the first advance
// adds the closing edge divide and a minimum-y pass.
// Result items come one per strobe cycle on result_valid and cannot be held.
`default_nettype none
module scanline_hachure_fill (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               func,
  input  wire logic signed [23:0] vertex_x,
  input  wire logic signed [23:0] vertex_y,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [23:0]        cfg_data,
  output logic                    result_valid,
  output logic                    span_valid,
  output logic signed [15:0]      span_x_start,
  output logic signed [15:0]      span_x_end,
  output logic signed [23:0]      span_y,
  output logic                    last,
  output logic                    done_res,
  output logic                    overflow
);

  localparam int AW  = shf_pkg::EDGE_AW;
  localparam int ECW = shf_pkg::ECW;
  localparam logic signed [24:0] Y_MAX_EXT = 25'(shf_pkg::Y_MAX);

  shf_pkg::state_t state, state_next;

  logic signed [23:0] cfg_gap;
  logic [20:0]        cfg_stroke;
  logic               have_vertex;
  logic signed [23:0] first_x, first_y, prev_x, prev_y;
  logic [ECW-1:0]     ec;
  logic signed [23:0] scan_y;
  logic               scanning;
  logic               dropped;
  logic               closing;
  logic signed [23:0] ed_low, ed_high;
  logic signed [47:0] ed_x;
  logic [ECW-1:0]     idx;
  logic [ECW-1:0]     na;
  logic               anyp;
  logic [ECW-1:0]     spans;
  logic [ECW-1:0]     rank;
  logic signed [47:0] best_x, prv_x;
  logic [ECW-1:0]     best_i, prv_i;
  logic               have_best;
  logic signed [15:0] xs_round;
  shf_pkg::edge_t     upd_e;

  // memory and unit hookups
  shf_pkg::edge_t     rd_e, wr_e;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  shf_pkg::div_req_t  div_req;
  shf_pkg::div_rsp_t  div_rsp;
  logic               xs_start, xs_done;
  logic signed [47:0] xs_x;

  // decode
  logic               acc, idx_last, ec_full, add_v, close_v;
  logic signed [23:0] ex2, ey2;
  logic               first_low;
  logic [23:0]        gap, graw;
  logic signed [24:0] ysum;
  shf_pkg::phase_t    ph_new;
  logic               key_cand, key_take, rank_last;
  logic               emit, emit_span, emit_last, emit_done;
  logic               min_take;

  function automatic logic key_lt(input logic signed [47:0] xa, input logic [ECW-1:0] ia,
                                  input logic signed [47:0] xb, input logic [ECW-1:0] ib);
    key_lt = (xa < xb) || ((xa == xb) && (ia < ib));
  endfunction

  shf_ram #(.WIDTH($bits(shf_pkg::edge_t)), .DEPTH(shf_pkg::MAX_EDGES)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (wr_e),
    .raddr (idx[AW-1:0]),
    .rdata (rd_e)
  );

  shf_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  shf_xstep u_xstep (
    .clk   (clk),
    .rst   (rst),
    .start (xs_start),
    .gap   (gap),
    .slope (rd_e.inv_slope),
    .x     (rd_e.cur_x),
    .done  (xs_done),
    .x_new (xs_x)
  );

  assign busy      = (state != shf_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  // Shared decode of the current item and sweep position
  always_comb begin
    acc       = start && (state == shf_pkg::S_IDLE);
    idx_last  = (ECW'(idx + 1'b1) == ec);
    ec_full   = (int'(ec) >= shf_pkg::MAX_EDGES - 1);
    add_v     = acc && (func == shf_pkg::FN_VERTEX) && !scanning && have_vertex &&
                (vertex_y != prev_y) && !ec_full;
    close_v   = acc && (func == shf_pkg::FN_ADVANCE) && !scanning && have_vertex &&
                (prev_y != first_y);
    ex2       = (func == shf_pkg::FN_VERTEX) ? vertex_x : first_x;
    ey2       = (func == shf_pkg::FN_VERTEX) ? vertex_y : first_y;
    first_low = (prev_y < ey2);
    graw      = cfg_gap[23] ? {1'b0, cfg_stroke, 2'b00} : cfg_gap;
    gap       = (graw < shf_pkg::GAP_MIN) ? shf_pkg::GAP_MIN : graw;
    ysum      = 25'(scan_y) + $signed({1'b0, gap});
    min_take  = (idx == '0) || (rd_e.low_y < $signed(best_x[23:0]));
    ph_new    = rd_e.phase;
    if ((ph_new == shf_pkg::PH_PENDING) && (rd_e.low_y <= scan_y)) ph_new = shf_pkg::PH_ACTIVE;
    if ((ph_new == shf_pkg::PH_ACTIVE) && (rd_e.high_y <= scan_y)) ph_new = shf_pkg::PH_RETIRED;
    key_cand  = (rd_e.phase == shf_pkg::PH_ACTIVE) &&
                ((rank == '0) || key_lt(prv_x, prv_i, rd_e.cur_x, idx));
    key_take  = key_cand && (!have_best || key_lt(rd_e.cur_x, idx, best_x, best_i));
    rank_last = (({1'b0, rank} + 1'b1) == {spans, 1'b0});
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      shf_pkg::S_IDLE: begin
        if (acc) begin
          if (func == shf_pkg::FN_VERTEX) begin
            state_next = add_v ? shf_pkg::S_DIV : shf_pkg::S_IDLE;
          end else if (scanning) begin
            state_next = shf_pkg::S_PH_RD;
          end else begin
            state_next = close_v ? shf_pkg::S_DIV : shf_pkg::S_CLOSE;
          end
        end
      end
      shf_pkg::S_DIV:      if (div_rsp.done) state_next = shf_pkg::S_EWRITE;
      shf_pkg::S_EWRITE:   state_next = closing ? shf_pkg::S_CLOSE : shf_pkg::S_IDLE;
      shf_pkg::S_CLOSE:    state_next = (ec == '0) ? shf_pkg::S_FINISH : shf_pkg::S_MIN_RD;
      shf_pkg::S_MIN_RD:   state_next = shf_pkg::S_MIN_CHK;
      shf_pkg::S_MIN_CHK:  state_next = idx_last ? shf_pkg::S_PH_RD : shf_pkg::S_MIN_RD;
      shf_pkg::S_PH_RD:    state_next = shf_pkg::S_PH_CHK;
      shf_pkg::S_PH_CHK:   state_next = idx_last ? shf_pkg::S_DECIDE : shf_pkg::S_PH_RD;
      shf_pkg::S_DECIDE: begin
        if ((na == '0) && !anyp) state_next = shf_pkg::S_FINISH;
        else if (na < ECW'(2))   state_next = shf_pkg::S_EMPTY;
        else                     state_next = shf_pkg::S_SORT_RD;
      end
      shf_pkg::S_SORT_RD:  state_next = shf_pkg::S_SORT_CHK;
      shf_pkg::S_SORT_CHK: state_next = idx_last ? shf_pkg::S_SORT_END : shf_pkg::S_SORT_RD;
      shf_pkg::S_SORT_END: state_next = rank_last ? shf_pkg::S_GAP : shf_pkg::S_SORT_RD;
      shf_pkg::S_EMPTY:    state_next = shf_pkg::S_GAP;
      shf_pkg::S_GAP:      state_next = shf_pkg::S_UPD_RD;
      shf_pkg::S_UPD_RD:   state_next = shf_pkg::S_UPD_CHK;
      shf_pkg::S_UPD_CHK: begin
        if (rd_e.phase == shf_pkg::PH_ACTIVE) state_next = shf_pkg::S_UPD_MUL;
        else state_next = idx_last ? shf_pkg::S_IDLE : shf_pkg::S_UPD_RD;
      end
      shf_pkg::S_UPD_MUL: begin
        if (xs_done) state_next = idx_last ? shf_pkg::S_IDLE : shf_pkg::S_UPD_RD;
      end
      shf_pkg::S_FINISH:   state_next = shf_pkg::S_IDLE;
      default:             state_next = shf_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer: memory writes, unit starts, result emits
  always_comb begin
    mem_we        = 1'b0;
    mem_waddr     = idx[AW-1:0];
    wr_e          = rd_e;
    div_req.start = add_v || close_v;
    div_req.num   = {25'(ex2) - 25'(prev_x), 16'h0000};
    div_req.den   = 25'(ey2) - 25'(prev_y);
    xs_start      = 1'b0;
    emit          = 1'b0;
    emit_span     = 1'b0;
    emit_last     = 1'b0;
    emit_done     = 1'b0;
    case (state)
      shf_pkg::S_EWRITE: begin
        mem_we          = 1'b1;
        mem_waddr       = ec[AW-1:0];
        wr_e.phase      = shf_pkg::PH_PENDING;
        wr_e.low_y      = ed_low;
        wr_e.high_y     = ed_high;
        wr_e.cur_x      = ed_x;
        wr_e.inv_slope  = div_rsp.quot;
      end
      shf_pkg::S_PH_CHK: begin
        mem_we     = 1'b1;
        wr_e.phase = ph_new;
      end
      shf_pkg::S_SORT_END: begin
        emit      = rank[0];
        emit_span = 1'b1;
        emit_last = rank_last;
      end
      shf_pkg::S_EMPTY: begin
        emit      = 1'b1;
        emit_last = 1'b1;
      end
      shf_pkg::S_UPD_CHK: begin
        xs_start = (rd_e.phase == shf_pkg::PH_ACTIVE);
      end
      shf_pkg::S_UPD_MUL: begin
        mem_we     = xs_done;
        wr_e       = upd_e;
        wr_e.cur_x = xs_x;
      end
      shf_pkg::S_FINISH: begin
        emit      = 1'b1;
        emit_last = 1'b1;
        emit_done = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= shf_pkg::S_IDLE;
      cfg_gap      <= -24'sd256;
      cfg_stroke   <= 21'd256;
      have_vertex  <= 1'b0;
      ec           <= '0;
      scan_y       <= '0;
      scanning     <= 1'b0;
      dropped      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= emit;
      if (cfg_valid) begin
        if (cfg_index == shf_pkg::CFG_HACHURE_GAP)  cfg_gap    <= cfg_data;
        if (cfg_index == shf_pkg::CFG_STROKE_WIDTH) cfg_stroke <= cfg_data[20:0];
      end
      case (state)
        shf_pkg::S_IDLE: begin
          if (acc && (func == shf_pkg::FN_VERTEX) && !scanning) begin
            if (!have_vertex) begin
              have_vertex <= 1'b1;
            end else if ((vertex_y != prev_y) && ec_full) begin
              dropped <= 1'b1;
            end
          end
        end
        shf_pkg::S_EWRITE: ec <= ec + 1'b1;
        shf_pkg::S_MIN_CHK: begin
          if (idx_last) begin
            scanning <= 1'b1;
            scan_y   <= min_take ? rd_e.low_y : $signed(best_x[23:0]);
          end
        end
        shf_pkg::S_GAP: begin
          scan_y <= (ysum > Y_MAX_EXT) ? shf_pkg::Y_MAX : ysum[23:0];
        end
        shf_pkg::S_FINISH: begin
          have_vertex <= 1'b0;
          ec          <= '0;
          scan_y      <= '0;
          scanning    <= 1'b0;
          dropped     <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers: vertex latch, edge staging, sweep state, result fields
  always_ff @(posedge clk) begin
    case (state)
      shf_pkg::S_IDLE: begin
        idx  <= '0;
        na   <= '0;
        anyp <= 1'b0;
        if (acc && (func == shf_pkg::FN_VERTEX) && !scanning) begin
          if (!have_vertex) begin
            first_x <= vertex_x;
            first_y <= vertex_y;
            prev_x  <= vertex_x;
            prev_y  <= vertex_y;
          end else if (!((vertex_y != prev_y) && ec_full)) begin
            prev_x <= vertex_x;
            prev_y <= vertex_y;
          end
        end
        closing <= (func == shf_pkg::FN_ADVANCE);
        ed_low  <= first_low ? prev_y : ey2;
        ed_high <= first_low ? ey2 : prev_y;
        ed_x    <= {{8{(first_low ? prev_x[23] : ex2[23])}},
                    (first_low ? prev_x : ex2), 16'h0000};
      end
      shf_pkg::S_CLOSE: idx <= '0;
      shf_pkg::S_MIN_CHK: begin
        // best_x low bits hold the running minimum of low y
        if (min_take) best_x <= 48'(rd_e.low_y);
        idx <= idx_last ? '0 : idx + 1'b1;
        na   <= '0;
        anyp <= 1'b0;
      end
      shf_pkg::S_PH_CHK: begin
        if (ph_new == shf_pkg::PH_ACTIVE)  na   <= na + 1'b1;
        if (ph_new == shf_pkg::PH_PENDING) anyp <= 1'b1;
        idx <= idx_last ? '0 : idx + 1'b1;
      end
      shf_pkg::S_DECIDE: begin
        spans     <= (int'(na >> 1) > shf_pkg::MAX_RESULTS) ? ECW'(shf_pkg::MAX_RESULTS)
                                                            : (na >> 1);
        rank      <= '0;
        have_best <= 1'b0;
        idx       <= '0;
      end
      shf_pkg::S_SORT_CHK: begin
        if (key_take) begin
          best_x    <= rd_e.cur_x;
          best_i    <= idx;
          have_best <= 1'b1;
        end
        idx <= idx_last ? '0 : idx + 1'b1;
      end
      shf_pkg::S_SORT_END: begin
        prv_x     <= best_x;
        prv_i     <= best_i;
        rank      <= rank + 1'b1;
        have_best <= 1'b0;
        idx       <= '0;
        if (!rank[0]) xs_round <= shf_pkg::round_q16(best_x);
      end
      shf_pkg::S_GAP: idx <= '0;
      shf_pkg::S_UPD_CHK: begin
        upd_e <= rd_e;
        if (rd_e.phase != shf_pkg::PH_ACTIVE) idx <= idx + 1'b1;
      end
      shf_pkg::S_UPD_MUL: if (xs_done) idx <= idx + 1'b1;
      default: begin
      end
    endcase
    if (emit) begin
      span_valid   <= emit_span;
      span_x_start <= emit_span ? xs_round : 16'sd0;
      span_x_end   <= emit_span ? shf_pkg::round_q16(best_x) : 16'sd0;
      span_y       <= scan_y;
      last         <= emit_last;
      done_res     <= emit_done;
      overflow     <= dropped;
    end
  end

endmodule
`default_nettype wire

// ===== src/shf_chk.sv =====
// Port-level checker for the scanline hachure fill, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module shf_chk (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               busy,
  input wire logic               result_valid,
  input wire logic               span_valid,
  input wire logic signed [15:0] span_x_start,
  input wire logic signed [15:0] span_x_end,
  input wire logic               last,
  input wire logic               done_res
);

  // finish item carries no span and closes the step
  `SHF_ASSERT_IMP(a_done_form, result_valid && done_res, !span_valid && last, "bad finish item")
  // spans come out ordered left to right
  `SHF_ASSERT_IMP(a_span_order, result_valid && span_valid, span_x_start <= span_x_end, "span reversed")
  // more items of a step follow only while the block is still working
  `SHF_ASSERT_IMP(a_more_busy, result_valid && !last, busy, "step ended early")
  // a result only follows a busy cycle
  `SHF_ASSERT_NXT(a_res_after_busy, !busy && !result_valid, !result_valid, "result from idle")

endmodule

bind scanline_hachure_fill shf_chk u_shf_chk (.*);
`default_nettype wire

// ===== tb/sv/tb_scanline_hachure_fill.sv =====
// Testbench of the scanline hachure fill: predicts span items and checks every one.
module tb_scanline_hachure_fill;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 80;
  localparam int NE = shf_pkg::MAX_EDGES;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic func = shf_pkg::FN_VERTEX;
  logic signed [23:0] vertex_x = '0;
  logic signed [23:0] vertex_y = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = shf_pkg::CFG_HACHURE_GAP;
  logic [23:0] cfg_data = '0;
  logic result_valid;
  logic span_valid;
  logic signed [15:0] span_x_start;
  logic signed [15:0] span_x_end;
  logic signed [23:0] span_y;
  logic last;
  logic done_res;
  logic overflow;

  scanline_hachure_fill dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .vertex_x(vertex_x), .vertex_y(vertex_y), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid), .span_valid(span_valid),
    .span_x_start(span_x_start), .span_x_end(span_x_end), .span_y(span_y),
    .last(last), .done_res(done_res), .overflow(overflow)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

  typedef struct {
    logic               sv;
    logic signed [15:0] xs;
    logic signed [15:0] xe;
    logic signed [23:0] y;
    logic               lst;
    logic               dn;
    logic               ovf;
  } span_item_t;

  span_item_t span_q[$];
  int errors = 0;
  int items_sent = 0;
  int spans_seen = 0;
  int polys_done = 0;
  bit no_idle = 1'b0;

  // Shadow copy of the fill state
  longint gap_reg, stroke_reg;
  int vcount, ecount;
  longint fx, fy, px, py;
  longint e_low[NE], e_high[NE], e_x[NE], e_slope[NE];
  shf_pkg::phase_t e_ph[NE];
  longint scan_y;
  bit scanning, dropped, poly_finished;

  function automatic void clear_fill();
    vcount = 0; ecount = 0; fx = 0; fy = 0; px = 0; py = 0;
    for (int i = 0; i < NE; i++) begin
      e_low[i] = 0; e_high[i] = 0; e_x[i] = 0; e_slope[i] = 0;
      e_ph[i] = shf_pkg::PH_PENDING;
    end
    scan_y = 0; scanning = 0; dropped = 0;
  endfunction

  function automatic void store_edge(longint x1, longint y1, longint x2, longint y2);
    bit lo_first;
    if (y1 == y2 || ecount >= NE) return;
    lo_first = y1 < y2;
    e_low[ecount] = lo_first ? y1 : y2;
    e_high[ecount] = lo_first ? y2 : y1;
    e_x[ecount] = (lo_first ? x1 : x2) * 65536;
    e_slope[ecount] = ((x2 - x1) * 65536) / (y2 - y1);
    e_ph[ecount] = shf_pkg::PH_PENDING;
    ecount++;
  endfunction

  function automatic logic signed [15:0] to_pixel(longint x);
    longint mag, r;
    mag = x < 0 ? -x : x;
    r = (mag + 32768) >>> 16;
    if (x < 0) r = -r;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  function automatic void push_span(bit v, longint xs, longint xe, bit l, bit d);
    span_item_t s;
    s.sv = v; s.xs = 16'(xs); s.xe = 16'(xe); s.y = 24'(scan_y);
    s.lst = l; s.dn = d; s.ovf = dropped;
    span_q = {span_q, s};
  endfunction

  function automatic void close_poly();
    push_span(0, 0, 0, 1, 1);
    clear_fill();
    poly_finished = 1;
  endfunction

  function automatic longint eff_gap();
    longint g;
    g = gap_reg < 0 ? stroke_reg * 4 : gap_reg;
    if (g < 26) g = 26;
    return g;
  endfunction

  // Coordinate spread that keeps a polygon to a modest number of scan steps
  function automatic int poly_span(int mult);
    longint s;
    s = eff_gap() * mult;
    if (s > 8388607) s = 8388607;
    return int'(s);
  endfunction

  // Expected span items of one accepted item
  function automatic void predict_fill(logic f, longint vx, longint vy);
    int ord[NE];
    int na, nsp, b, v;
    bit pend;
    longint m, g;
    logic signed [79:0] pg, ps, st, sum;
    if (f == shf_pkg::FN_VERTEX) begin
      if (scanning) return;
      if (vcount == 0) begin
        fx = vx; px = vx; fy = vy; py = vy; vcount = 1;
        return;
      end
      if (vy != py && ecount >= NE - 1) begin
        dropped = 1;
        return;
      end
      store_edge(px, py, vx, vy);
      px = vx; py = vy;
      if (vcount < 511) vcount++;
      return;
    end
    if (!scanning) begin
      if (vcount > 0) store_edge(px, py, fx, fy);
      if (ecount == 0) begin
        close_poly();
        return;
      end
      m = e_low[0];
      for (int i = 1; i < ecount; i++) if (e_low[i] < m) m = e_low[i];
      scan_y = m;
      scanning = 1;
    end
    na = 0; pend = 0;
    for (int i = 0; i < ecount; i++) begin
      if (e_ph[i] == shf_pkg::PH_PENDING && e_low[i] <= scan_y) e_ph[i] = shf_pkg::PH_ACTIVE;
      if (e_ph[i] == shf_pkg::PH_ACTIVE && e_high[i] <= scan_y) e_ph[i] = shf_pkg::PH_RETIRED;
      if (e_ph[i] == shf_pkg::PH_ACTIVE) begin
        ord[na] = i;
        na++;
      end else if (e_ph[i] == shf_pkg::PH_PENDING) begin
        pend = 1;
      end
    end
    if (na == 0 && !pend) begin
      close_poly();
      return;
    end
    // stable insertion sort by current x
    for (int a = 1; a < na; a++) begin
      v = ord[a]; b = a;
      while (b > 0 && e_x[ord[b-1]] > e_x[v]) begin
        ord[b] = ord[b-1];
        b--;
      end
      ord[b] = v;
    end
    nsp = na / 2;
    if (nsp > shf_pkg::MAX_RESULTS) nsp = shf_pkg::MAX_RESULTS;
    if (nsp == 0) push_span(0, 0, 0, 1, 0);
    for (int s = 0; s < nsp; s++)
      push_span(1, to_pixel(e_x[ord[2*s]]), to_pixel(e_x[ord[2*s+1]]), s + 1 == nsp, 0);
    g = eff_gap();
    scan_y += g;
    if (scan_y > 8388607) scan_y = 8388607;
    for (int i = 0; i < ecount; i++) begin
      if (e_ph[i] == shf_pkg::PH_ACTIVE) begin
        pg = 80'(g); ps = 80'(e_slope[i]);
        st = (pg * ps) >>> 8;
        sum = 80'(e_x[i]) + st;
        if (sum > 80'sh7FFF_FFFF_FFFF) sum = 80'sh7FFF_FFFF_FFFF;
        if (sum < -80'sh8000_0000_0000) sum = -80'sh8000_0000_0000;
        e_x[i] = 64'(sum);
      end
    end
  endfunction

  // Result checker
  task automatic check_field(string nm, longint e, longint a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, nm, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    span_item_t x;
    if (!rst && result_valid) begin
      if (span_q.size() == 0) begin
        $display("%0t: unexpected span item, expected none, got y %0d", $time, span_y);
        errors++;
      end else begin
        x = span_q.pop_front();
        check_field("span_valid", x.sv, span_valid);
        check_field("span_x_start", x.xs, span_x_start);
        check_field("span_x_end", x.xe, span_x_end);
        check_field("span_y", x.y, span_y);
        check_field("last", x.lst, last);
        check_field("done_res", x.dn, done_res);
        check_field("overflow", x.ovf, overflow);
        if (span_valid) spans_seen++;
        if (done_res) polys_done++;
      end
    end
  end

  // Send one item; start is left high so a following item can go back to back
  task automatic send_item(logic f, logic signed [23:0] x, logic signed [23:0] y);
    if (!no_idle && $urandom_range(99) < 25) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 25);
    end
    start <= 1'b1;
    func <= f;
    vertex_x <= x;
    vertex_y <= y;
    do @(posedge clk); while (busy);
    predict_fill(f, x, y);
    items_sent++;
  endtask

  // Drop start and wait until the block is quiet
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (span_q.size() != 0 || busy);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    if (idx == shf_pkg::CFG_HACHURE_GAP) gap_reg = longint'(signed'(d));
    else stroke_reg = longint'(d[20:0]);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Advance until the polygon closes, with a few stray vertices mixed in when noise is set
  task automatic scan_out(bit noise);
    poly_finished = 0;
    while (!poly_finished) begin
      if (noise && scanning && $urandom_range(99) < 8)
        send_item(shf_pkg::FN_VERTEX, 24'($urandom), 24'($urandom));
      send_item(shf_pkg::FN_ADVANCE, 24'($urandom), 24'($urandom));
    end
  endtask

  task automatic random_polygon(int nv, int span, bit noise);
    for (int i = 0; i < nv; i++)
      send_item(shf_pkg::FN_VERTEX, 24'($urandom_range(2 * span) - span),
                24'($urandom_range(2 * span) - span));
    scan_out(noise);
  endtask

  task automatic test_corners();
    // empty polygon and single vertex both finish at once
    send_item(shf_pkg::FN_ADVANCE, 24'sh7FFFFF, -24'sh800000);
    send_item(shf_pkg::FN_VERTEX, 24'sh7FFFFF, -24'sh800000);
    send_item(shf_pkg::FN_ADVANCE, 24'sh0, 24'sh0);
    // triangle at the field extremes, gap saturates y
    send_item(shf_pkg::FN_VERTEX, -24'sh800000, -24'sh800000);
    send_item(shf_pkg::FN_VERTEX, 24'sh7FFFFF, 24'sh000000);
    send_item(shf_pkg::FN_VERTEX, -24'sh800000, 24'sh7FFFFF);
    scan_out(0);
    drain();
  endtask

  task automatic test_horizontal_and_comb();
    // square with horizontal top and bottom
    send_item(shf_pkg::FN_VERTEX, -24'sd1024, -24'sd512);
    send_item(shf_pkg::FN_VERTEX, 24'sd1024, -24'sd512);
    send_item(shf_pkg::FN_VERTEX, 24'sd1024, 24'sd512);
    send_item(shf_pkg::FN_VERTEX, -24'sd1024, 24'sd512);
    scan_out(1);
    // comb of twenty teeth: the first sixteen fill every span slot, extra vertices overflow
    for (int t = 0; t < 20; t++) begin
      send_item(shf_pkg::FN_VERTEX, 24'(t * 512), 24'sd0);
      send_item(shf_pkg::FN_VERTEX, 24'(t * 512 + 256), 24'sd1024);
    end
    send_item(shf_pkg::FN_VERTEX, 24'sd10240, -24'sd256);
    send_item(shf_pkg::FN_VERTEX, 24'sd0, -24'sd256);
    scan_out(0);
    drain();
  endtask

  task automatic test_random(int target);
    while (items_sent < target) begin
      case ($urandom_range(9))
        0: random_polygon($urandom_range(2, 8), poly_span(16), 1);
        1: random_polygon($urandom_range(34, 40), poly_span(3), 0);
        default: random_polygon($urandom_range(3, 8), poly_span(5), 1);
      endcase
      if ($urandom_range(5) == 0) drain();
    end
    drain();
  endtask

  initial begin
    clear_fill();
    gap_reg = -256;
    stroke_reg = 256;
    poly_finished = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_reg(shf_pkg::CFG_HACHURE_GAP, 24'h7FFFFF);
    test_corners();
    write_reg(shf_pkg::CFG_HACHURE_GAP, 24'd256);
    write_reg(shf_pkg::CFG_STROKE_WIDTH, 24'd64);
    test_horizontal_and_comb();
    // negative gap: four times stroke width, then the minimum gap
    write_reg(shf_pkg::CFG_HACHURE_GAP, 24'h800000);
    no_idle = 1'b1;
    test_random(items_sent + 40);
    no_idle = 1'b0;
    write_reg(shf_pkg::CFG_STROKE_WIDTH, 24'd0);
    test_random(items_sent + 30);
    write_reg(shf_pkg::CFG_STROKE_WIDTH, 24'h1FFFFF);
    test_random(items_sent + 20);
    write_reg(shf_pkg::CFG_HACHURE_GAP, 24'd0);
    test_random(items_sent + 30);
    // random gap settings for the rest
    while (items_sent < 300) begin
      write_reg(shf_pkg::CFG_HACHURE_GAP, 24'($urandom_range(100, 700)));
      write_reg(shf_pkg::CFG_STROKE_WIDTH, 24'($urandom_range(0, 2097151)));
      test_random(items_sent + 40);
    end
    drain();
    $display("Sent %0d items over %0d polygons, %0d spans checked.",
             items_sent, polys_done, spans_seen);
    $display("Gap settings covered positive, negative, zero and saturating values.");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
